@@ src/mshu_pkg.sv @@
package mshu_pkg;

  localparam int unsigned PRE_DEPTH = 28;
  localparam int unsigned PRE_BITS  = PRE_DEPTH * 8;
  localparam logic [31:0] MIX_GOLD  = 32'h9E3779B9;
  localparam logic [31:0] SEED_MUL  = 32'd137;
  localparam logic [31:0] SEED_STEP = 32'd71;
  localparam logic [31:0] KEY_MUL   = 32'd73;

  localparam logic [31:0] INIT_WORDS [8] = '{
    32'h86B47C4C, 32'hEEDFCBB3, 32'h1105DC08, 32'h21FB8A71,
    32'h43B675C9, 32'h75B803D5, 32'h864FAAE8, 32'hD7C261FF
  };

  localparam logic [0:0] REG_ROUNDS = 1'b0;
  localparam logic [0:0] REG_STAGES = 1'b1;

  typedef struct packed {
    logic [PRE_BITS-1:0] pre;
    logic [4:0]          cnt;
    logic [31:0]         sum;
  } job_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mix2(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] mid;
    mid  = (y * 32'd19) + rotl(x, 11) + rotl(y, 15) + (x >> 3);
    mix2 = (x * 32'd33) ^ mid ^ (y << 2);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
  endfunction

  function automatic logic [2:0] blk_sel(input logic [2:0] j, input logic [2:0] n);
    logic [2:0] r;
    r = j;
    for (int k = 0; k < 6; k++) begin
      if (r >= n) r = r - n;
    end
    blk_sel = r;
  endfunction

endpackage

@@ src/mshu_front.sv @@
module mshu_front import mshu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  logic [31:0]         sum_r, sum_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                ended_r, ended_nxt;
  logic [PRE_BITS-1:0] pre_r, pre_nxt;
  logic                fire;

  assign in_tready = job_ready;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    pre_nxt   = pre_r;
    if (!ended_r) begin
      if (in_tdata == 8'd0) begin
        ended_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + {24'd0, in_tdata};
        if (cnt_r < 5'(PRE_DEPTH)) begin
          pre_nxt[cnt_r*8 +: 8] = in_tdata;
          cnt_nxt = cnt_r + 5'd1;
        end
      end
    end
  end

  assign job_valid = fire && in_tlast;
  assign job.sum   = sum_nxt;
  assign job.cnt   = cnt_nxt;
  assign job.pre   = pre_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else if (fire) begin
      if (in_tlast) begin
        sum_r   <= '0;
        cnt_r   <= '0;
        ended_r <= 1'b0;
      end else begin
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) pre_r <= pre_nxt;
  end

endmodule

@@ src/mshu_queue.sv @@
module mshu_queue import mshu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       push, pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/mshu_back.sv @@
module mshu_back import mshu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  round_count,
  input  logic [3:0]  stage_count,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEED = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_BLK  = 4'd3;
  localparam logic [3:0] S_KEY0 = 4'd4;
  localparam logic [3:0] S_KEY1 = 4'd5;
  localparam logic [3:0] S_KEY2 = 4'd6;
  localparam logic [3:0] S_MA   = 4'd7;
  localparam logic [3:0] S_MB   = 4'd8;
  localparam logic [3:0] S_SEND = 4'd9;
  localparam logic [3:0] S_HSUM = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;
  localparam logic [3:0] S_ERR  = 4'd12;

  logic [3:0]          st_r, st_nxt;
  logic [31:0]         h_r [8];
  logic [31:0]         h_nxt [8];
  logic [31:0]         blk_r [7];
  logic [PRE_BITS-1:0] pre_r, pre_nxt;
  logic [4:0]          rem_r, rem_nxt;
  logic [2:0]          nblk_r, nblk_nxt;
  logic [31:0]         sum_r, sum_nxt;
  logic [31:0]         seed_r, seed_nxt;
  logic [31:0]         chain_r, chain_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [3:0]          stg_r, stg_nxt;
  logic [7:0]          rnd_r, rnd_nxt;
  logic [2:0]          m6_r, m6_nxt;
  logic [2:0]          step_r, step_nxt;
  logic                ov_r, ov_nxt;
  logic [39:0]         od_r, od_nxt;
  logic                ol_r, ol_nxt;
  logic                oe_r, oe_nxt;
  logic                blk_we;
  logic [31:0]         blk_val;
  logic                out_free;
  logic [31:0]         hsel, bsel, tmp1, csum;
  logic [4:0]          stages;
  logic [2:0]          hidx;
  logic [31:0]         tmp [8];

  assign out_free  = !ov_r || out_tready;
  assign job_ready = (st_r == S_IDLE);
  assign stages    = (stage_count == 4'd0) ? 5'd1 : {1'b0, stage_count};

  always_comb begin
    unique case (st_r)
      S_KEY0:  hidx = rnd_r[2:0];
      S_KEY1:  hidx = rnd_r[2:0] + 3'd3;
      S_KEY2:  hidx = rnd_r[2:0] + 3'd5;
      default: hidx = step_r;
    endcase
  end

  assign hsel = h_r[hidx];
  assign bsel = blk_r[blk_sel({step_r[1:0], 1'b0}, nblk_r)];

  always_comb begin
    csum = '0;
    for (int n = 0; n < 8; n++) begin
      csum = csum + {24'd0, hex_char(hsel[31-4*n -: 4])};
    end
  end

  always_comb begin
    blk_val = '0;
    for (int k = 0; k < 4; k++) begin
      blk_val[8*k +: 8] = (5'(k) < rem_r) ? pre_r[8*k +: 8] : 8'h20;
    end
    blk_val = blk_val ^ (seed_r >> step_r);
  end

  always_comb begin
    st_nxt    = st_r;
    pre_nxt   = pre_r;
    rem_nxt   = rem_r;
    nblk_nxt  = nblk_r;
    sum_nxt   = sum_r;
    seed_nxt  = seed_r;
    chain_nxt = chain_r;
    key_nxt   = key_r;
    stg_nxt   = stg_r;
    rnd_nxt   = rnd_r;
    m6_nxt    = m6_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    oe_nxt    = oe_r;
    blk_we    = 1'b0;
    tmp1      = '0;
    for (int k = 0; k < 8; k++) begin
      h_nxt[k] = h_r[k];
      tmp[k]   = h_r[k];
    end

    unique case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          if (job.cnt == 5'd0) begin
            st_nxt = S_ERR;
          end else begin
            pre_nxt   = job.pre;
            rem_nxt   = job.cnt;
            nblk_nxt  = (job.cnt >= 5'd25) ? 3'd7 : 3'((job.cnt + 5'd3) >> 2);
            sum_nxt   = job.sum;
            chain_nxt = '0;
            stg_nxt   = '0;
            st_nxt    = S_SEED;
          end
        end
      end
      S_SEED: begin
        seed_nxt = sum_r * SEED_MUL;
        st_nxt   = S_INIT;
      end
      S_INIT: begin
        for (int k = 0; k < 8; k++) h_nxt[k] = INIT_WORDS[k] ^ seed_r ^ chain_r;
        step_nxt = '0;
        st_nxt   = S_BLK;
      end
      S_BLK: begin
        blk_we   = 1'b1;
        seed_nxt = rotl(seed_r, 5) ^ (seed_r * SEED_STEP);
        pre_nxt  = pre_r >> 32;
        rem_nxt  = (rem_r >= 5'd4) ? rem_r - 5'd4 : 5'd0;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) begin
          rnd_nxt  = '0;
          m6_nxt   = '0;
          step_nxt = '0;
          st_nxt   = (round_count == 8'd0) ? S_SEND : S_KEY0;
        end
      end
      S_KEY0: begin
        key_nxt = MIX_GOLD ^ ({24'd0, rnd_r} * KEY_MUL) ^ (hsel << m6_r);
        st_nxt  = S_KEY1;
      end
      S_KEY1: begin
        key_nxt = key_r ^ (hsel >> rnd_r[1:0]);
        st_nxt  = S_KEY2;
      end
      S_KEY2: begin
        key_nxt  = key_r ^ (hsel << rnd_r[2:0]);
        step_nxt = '0;
        st_nxt   = S_MA;
      end
      S_MA: begin
        h_nxt[0] = mix2(h_r[0], key_r) ^ (bsel + MIX_GOLD) ^ (h_r[1] ^ h_r[3]);
        st_nxt   = S_MB;
      end
      S_MB: begin
        tmp1 = mix2(h_r[1], rotl(h_r[0], 13)) ^ (h_r[3] >> 5) ^ (h_r[6] << 3)
             ^ rotl(h_r[7], 17) ^ (h_r[1] ^ h_r[3]);
        tmp[1] = tmp1;
        for (int k = 0; k < 8; k++) h_nxt[k] = tmp[3'(k + 2)];
        step_nxt = step_r + 3'd1;
        st_nxt   = S_MA;
        if (step_r == 3'd3) begin
          step_nxt = '0;
          rnd_nxt  = rnd_r + 8'd1;
          m6_nxt   = (m6_r == 3'd5) ? 3'd0 : m6_r + 3'd1;
          st_nxt   = ({1'b0, rnd_r} + 9'd1 == {1'b0, round_count}) ? S_SEND : S_KEY0;
        end
      end
      S_SEND: begin
        chain_nxt = chain_r ^ h_r[0];
        step_nxt  = '0;
        if ({1'b0, stg_r} + 5'd1 >= stages) begin
          st_nxt = S_OUT;
        end else begin
          stg_nxt = stg_r + 4'd1;
          sum_nxt = '0;
          st_nxt  = S_HSUM;
        end
      end
      S_HSUM: begin
        sum_nxt  = sum_r + csum;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          for (int w = 0; w < 4; w++) begin
            for (int n = 0; n < 8; n++) begin
              if (w * 8 + n < PRE_DEPTH)
                pre_nxt[8*(w*8+n) +: 8] = hex_char(h_r[w][31-4*n -: 4]);
            end
          end
          rem_nxt  = 5'(PRE_DEPTH);
          nblk_nxt = 3'd7;
          step_nxt = '0;
          st_nxt   = S_SEED;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          od_nxt   = {5'd0, step_r, hsel};
          ol_nxt   = (step_r == 3'd7);
          oe_nxt   = 1'b0;
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd7) st_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          ol_nxt = 1'b1;
          oe_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ov_r  <= 1'b0;
      stg_r <= '0;
      rnd_r <= '0;
      m6_r  <= '0;
      step_r <= '0;
      chain_r <= '0;
      for (int k = 0; k < 8; k++) h_r[k] <= '0;
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      stg_r   <= stg_nxt;
      rnd_r   <= rnd_nxt;
      m6_r    <= m6_nxt;
      step_r  <= step_nxt;
      chain_r <= chain_nxt;
      for (int k = 0; k < 8; k++) h_r[k] <= h_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    pre_r  <= pre_nxt;
    rem_r  <= rem_nxt;
    nblk_r <= nblk_nxt;
    sum_r  <= sum_nxt;
    seed_r <= seed_nxt;
    key_r  <= key_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
    oe_r   <= oe_nxt;
    if (blk_we) blk_r[step_r] <= blk_val;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = oe_r;

endmodule

@@ src/multi_stage_mixing_hash_256_unit.sv @@
// Input: one byte transaction per cycle while the job queue has room.
// After the last byte, each stage runs seed, init and block setup, then round_count rounds
// on the shared round mixer (key in S_KEY0, S_KEY1 and S_KEY2, eight half-steps);
// every stage after the first adds a hex-summing pass. Then eight output words.
// Reset (synchronous, rst_n low) clears message, chain and control state;
// round_count returns to 8 and stage_count to 2.
module multi_stage_mixing_hash_256_unit import mshu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // message_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero pad
  output logic        out_tlast,  // last_word
  output logic        out_tuser,  // empty_error
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] rounds_r;
  logic [3:0] stages_r;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  job_t       fq_job, qb_job;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_STAGES) ? {28'd0, stages_r} : {24'd0, rounds_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r <= 8'd8;
      stages_r <= 4'd2;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_ROUNDS) rounds_r <= cfg_pwdata[7:0];
      else stages_r <= cfg_pwdata[3:0];
    end
  end

  mshu_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  mshu_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  mshu_back u_back (
    .clk, .rst_n, .round_count(rounds_r), .stage_count(stages_r),
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

`ifndef NO_ASSERTIONS
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 40'd0)
    else $error("error result not final");
  a_idx_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tlast == (out_tdata[34:32] == 3'd7)))
    else $error("last_word mismatch");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:35] == 5'd0)
    else $error("pad bits set");
`endif

endmodule

@@ dv/tb_multi_stage_mixing_hash_256_unit.sv @@
`timescale 1ns / 1ps

module tb_multi_stage_mixing_hash_256_unit;
  import mshu_pkg::*;

  localparam int unsigned IDLE_LIMIT = 400000;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
    bit        empty;
  } digest_beat_t;

  class digest_scoreboard;
    bit [7:0]     round_cfg = 8;
    bit [3:0]     stage_cfg = 2;
    bit [31:0]    msg_sum;
    bit [7:0]     head_bytes [PRE_DEPTH];
    int unsigned  n_captured;
    bit           text_done;
    bit [31:0]    hw [8];
    digest_beat_t pending_beats [$];
    int unsigned  n_errors;
    int unsigned  n_checked;

    function bit [31:0] rol(bit [31:0] x, int unsigned n);
      n = n % 32;
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function bit [31:0] mixw(bit [31:0] x, bit [31:0] y);
      bit [31:0] mid;
      mid = (y * 32'd19) + rol(x, 11) + rol(y, 15) + (x >> 3);
      return (x * 32'd33) ^ mid ^ (y << 2);
    endfunction

    function void hash_stage(bit [7:0] pre [PRE_DEPTH], int unsigned cnt, bit [31:0] sum,
                             bit [31:0] prev);
      bit [31:0]   blk [7];
      bit [31:0]   seed;
      bit [31:0]   v;
      bit [31:0]   key;
      bit [31:0]   px;
      int unsigned nblk;
      nblk = (cnt + 3) / 4;
      if (nblk > 7) nblk = 7;
      if (nblk == 0) nblk = 1;
      seed = sum * SEED_MUL;
      for (int i = 0; i < 7; i++) blk[i] = 0;
      for (int i = 0; i < nblk; i++) begin
        v = 0;
        for (int k = 0; k < 4; k++)
          v |= ((i * 4 + k < cnt) ? 32'(pre[i * 4 + k]) : 32'h20) << (8 * k);
        blk[i] = v ^ (seed >> (i % 16));
        seed = rol(seed, 5) ^ (seed * SEED_STEP);
      end
      seed = sum * SEED_MUL;
      for (int i = 0; i < 8; i++) hw[i] = INIT_WORDS[i] ^ seed ^ prev;
      for (int unsigned i = 0; i < round_cfg; i++) begin
        key = MIX_GOLD ^ (i * KEY_MUL) ^ (hw[i % 8] << (i % 6))
            ^ (hw[(i + 3) % 8] >> (i % 4)) ^ (hw[(i + 5) % 8] << (i % 8));
        for (int j = 0; j < 8; j += 2) begin
          px = hw[j + 1] ^ hw[(j + 3) % 8];
          hw[j] = mixw(hw[j], key) ^ (blk[j % nblk] + MIX_GOLD) ^ px;
          hw[j + 1] = mixw(hw[j + 1], rol(hw[j], 13)) ^ (hw[(j + 3) % 8] >> 5)
                    ^ (hw[(j + 6) % 8] << 3) ^ rol(hw[(j + 7) % 8], 17) ^ px;
        end
      end
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      bit [7:0]    hex [PRE_DEPTH];
      bit [31:0]   hsum;
      bit [31:0]   chain;
      bit [3:0]    nib;
      bit [7:0]    c;
      int unsigned stages;
      digest_beat_t r;
      if (!text_done) begin
        if (b == 0) text_done = 1;
        else begin
          msg_sum += b;
          if (n_captured < PRE_DEPTH) begin
            head_bytes[n_captured] = b;
            n_captured++;
          end
        end
      end
      if (!last) return;
      if (n_captured == 0) begin
        r = '{word: 0, idx: 0, last: 1, empty: 1};
        pending_beats.push_back(r);
      end else begin
        stages = (stage_cfg == 0) ? 1 : stage_cfg;
        chain = 0;
        for (int s = 0; s < stages; s++) begin
          if (s == 0) hash_stage(head_bytes, n_captured, msg_sum, chain);
          else begin
            hsum = 0;
            for (int k = 0; k < 64; k++) begin
              nib = 4'(hw[k / 8] >> (28 - 4 * (k % 8)));
              c = (nib < 10) ? 8'h30 + nib : 8'h57 + nib;
              hsum += c;
              if (k < PRE_DEPTH) hex[k] = c;
            end
            hash_stage(hex, PRE_DEPTH, hsum, chain);
          end
          chain ^= hw[0];
        end
        for (int k = 0; k < 8; k++) begin
          r = '{word: hw[k], idx: 3'(k), last: (k == 7), empty: 0};
          pending_beats.push_back(r);
        end
      end
      msg_sum = 0;
      n_captured = 0;
      text_done = 0;
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
      $display("mismatch %0s: got %h expected %h", what, got, want);
      n_errors++;
    endtask

    task check_beat(digest_beat_t got);
      digest_beat_t want;
      n_checked++;
      if (pending_beats.size() == 0) begin
        report("unexpected transaction", got.word, 0);
        return;
      end
      want = pending_beats.pop_front();
      if (got.word != want.word) report("digest_word", got.word, want.word);
      if (got.idx != want.idx) report("word_index", got.idx, want.idx);
      if (got.last != want.last) report("last_word", got.last, want.last);
      if (got.empty != want.empty) report("empty_error", got.empty, want.empty);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // message_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // digest_word[31:0], word_index[34:32], zero pad
  logic        out_tlast;  // last_word
  logic        out_tuser;  // empty_error
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  digest_scoreboard digests;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned n_bytes;
  int unsigned n_msgs;
  int unsigned n_cfg_writes;

  multi_stage_mixing_hash_256_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    digest_beat_t beat;
    if (rst_n && out_tvalid && out_tready) begin
      beat = '{word: out_tdata[31:0], idx: out_tdata[34:32], last: out_tlast,
               empty: out_tuser};
      digests.check_beat(beat);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d transactions outstanding",
               digests.pending_beats.size());
      $display("tb_multi_stage_mixing_hash_256_unit NOT OK");
      $finish;
    end
  end

  task send_byte(bit [7:0] b, bit last);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    digests.note_byte(b, last);
    n_bytes++;
    if (last) n_msgs++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task send_message(int unsigned len, bit [7:0] fill);
    for (int i = 0; i < len; i++)
      send_byte(fill == 0 ? 8'($urandom_range(1, 255)) : fill, i == len - 1);
  endtask

  task send_random_message(int unsigned max_len);
    int unsigned len;
    bit [7:0]    b;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(24) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  task drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digests.pending_beats.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(bit idx, bit [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_ROUNDS) digests.round_cfg = val[7:0];
    else digests.stage_cfg = val[3:0];
    n_cfg_writes++;
  endtask

  task set_config(bit [7:0] rounds, bit [3:0] stages);
    write_reg(REG_ROUNDS, 32'(rounds));
    write_reg(REG_STAGES, 32'(stages));
  endtask

  initial begin
    int unsigned idle_mode [4][2];
    digests = new();
    idle_mode = '{'{0, 0}, '{48, 0}, '{0, 48}, '{33, 33}};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset configuration
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    for (int i = 0; i < 29; i++) send_byte(i[0] ? 8'hFF : 8'(8'h80 + i), i == 28);
    drain();

    // extremes of the registers
    set_config(0, 1);
    send_message(3, 0);
    send_byte(8'h7F, 1'b1);
    drain();
    set_config(255, 15);
    send_message(2, 0);
    drain();
    set_config(255, 1);
    send_message(5, 0);
    drain();
    set_config(1, 15);
    send_message(4, 0);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mode[p][0];
      recv_stall_pct = idle_mode[p][1];
      set_config(8'($urandom_range(0, 12)), 4'($urandom_range(1, 4)));
      while (n_bytes < 40 + 60 * (p + 1)) send_random_message(10);
      if (p == 1) begin
        hold_left = 800;
        for (int m = 0; m < 12; m++) send_random_message(2);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    $display("sent %0d bytes in %0d messages, %0d register writes",
             n_bytes, n_msgs, n_cfg_writes);
    $display("checked %0d digest transactions, %0d mismatches",
             digests.n_checked, digests.n_errors);
    if (digests.n_errors == 0 && digests.pending_beats.size() == 0) begin
      $display("tb_multi_stage_mixing_hash_256_unit OK");
    end else begin
      $display("tb_multi_stage_mixing_hash_256_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mshu_pkg.sv
src/mshu_front.sv
src/mshu_queue.sv
src/mshu_back.sv
src/multi_stage_mixing_hash_256_unit.sv
dv/tb_multi_stage_mixing_hash_256_unit.sv
